// ===== hw/rtl/mesh_face_adjacency_and_centroid_macros.svh =====
// Assertion macros for the mesh face adjacency and centroid block.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef MESH_FACE_ADJACENCY_AND_CENTROID_MACROS_SVH
`define MESH_FACE_ADJACENCY_AND_CENTROID_MACROS_SVH

// same-cycle implication, disabled during reset
`define MFAC_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define MFAC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/mfac_pkg.sv =====
// Package for the mesh face adjacency and centroid block.
// Types, constants and control structs shared by all RTL files; no dependencies.
package mfac_pkg;

   localparam int EDGE_TABLE_DEPTH_DEF = 1024;

   localparam int VID_W  = 16;
   localparam int POS_W  = 32;
   localparam int SUM_W  = 40;
   localparam int CCNT_W = 8;

   localparam logic [CCNT_W-1:0] MAX_CORNERS = 8'd255;

   localparam logic KIND_ADJ      = 1'b0;
   localparam logic KIND_CENTROID = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_ADJ_OUT,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_CEN_OUT
   } state_type;

   typedef enum logic {
      TBL_IDLE,
      TBL_SCAN
   } tbl_state_type;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef struct packed {
      logic [VID_W-1:0] v_start;
      logic [VID_W-1:0] v_end;
      logic [VID_W-1:0] face;
   } edge_entry_type;

   typedef struct packed {
      logic           start;
      edge_entry_type key;
   } tbl_cmd_type;

   typedef struct packed {
      logic             done;
      logic             found;
      logic             dropped;
      logic [VID_W-1:0] neighbour;
   } tbl_status_type;

   typedef struct packed {
      logic              start;
      logic [SUM_W-1:0]  dividend;
      logic [CCNT_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_status_type;

endpackage

// ===== hw/rtl/mesh_face_adjacency_and_centroid.sv =====
// Top level of the mesh face adjacency and centroid block.
// Depends on mfac_pkg, mfac_edge_table, mfac_divider and the assertion macro header.
//
// One face corner per item. The corner's undirected edge is scanned against the
// edge table in order through the table memory's single read port, one entry per
// cycle; a miss appends the edge or, with the table full, sets the sticky
// edges_dropped flag. A match yields one adjacency result. On a face's last corner
// the three mean coordinates go one after the other through one shared bit-serial
// divider, then the centroid result (x negated, saturated) is presented. Each
// result waits on rsp_ready; req_ready is high only when the block is idle. The
// edge table needs no clearing pass after reset.
`include "mesh_face_adjacency_and_centroid_macros.svh"

module mesh_face_adjacency_and_centroid #(
   parameter int EDGE_TABLE_DEPTH = mfac_pkg::EDGE_TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_face_id,
   input  logic [15:0] req_corner_vertex,
   input  logic [15:0] req_following_vertex,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic        req_face_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [15:0] rsp_face_current,
   output logic [15:0] rsp_face_neighbour,
   output logic signed [31:0] rsp_centroid_x,
   output logic signed [31:0] rsp_centroid_y,
   output logic signed [31:0] rsp_centroid_z,
   output logic        rsp_edges_dropped,
   output logic        rsp_run_last
);

   localparam int SUM_W  = mfac_pkg::SUM_W;
   localparam int POS_W  = mfac_pkg::POS_W;
   localparam int VID_W  = mfac_pkg::VID_W;
   localparam int CCNT_W = mfac_pkg::CCNT_W;
   localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

   mfac_pkg::state_type state_ff, state_in;
   mfac_pkg::axis_type  axis_ff, axis_in;

   logic [VID_W-1:0]  face_ff, face_in;
   logic [VID_W-1:0]  va_ff, va_in;
   logic [VID_W-1:0]  vb_ff, vb_in;
   logic              end_ff, end_in;
   logic [SUM_W-1:0]  sum_x_ff, sum_x_in;
   logic [SUM_W-1:0]  sum_y_ff, sum_y_in;
   logic [SUM_W-1:0]  sum_z_ff, sum_z_in;
   logic [CCNT_W-1:0] ccnt_ff, ccnt_in;
   logic              overflow_ff, overflow_in;
   logic [VID_W-1:0]  nb_ff, nb_in;
   logic              sign_ff, sign_in;
   logic [POS_W-1:0]  cen_x_ff, cen_x_in;
   logic [POS_W-1:0]  cen_y_ff, cen_y_in;
   logic [POS_W-1:0]  cen_z_ff, cen_z_in;

   mfac_pkg::tbl_cmd_type    tbl_cmd;
   mfac_pkg::tbl_status_type tbl_status;
   mfac_pkg::div_cmd_type    div_cmd;
   mfac_pkg::div_status_type div_status;

   logic             req_accept;
   logic [SUM_W-1:0] sel_sum;
   logic [SUM_W-1:0] sel_mag;
   logic [POS_W-1:0] quo_lo;
   logic [POS_W-1:0] mean_val;
   logic [POS_W-1:0] neg_val;

   mfac_edge_table #(
      .EDGE_TABLE_DEPTH(EDGE_TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (tbl_cmd),
      .status(tbl_status)
   );

   mfac_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .status(div_status)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mfac_pkg::ST_IDLE:
            if (req_valid) state_in = mfac_pkg::ST_SEARCH;
         mfac_pkg::ST_SEARCH: begin
            if (tbl_status.done) begin
               priority if (tbl_status.found) state_in = mfac_pkg::ST_ADJ_OUT;
               else if (end_ff)               state_in = mfac_pkg::ST_DIV_START;
               else                           state_in = mfac_pkg::ST_IDLE;
            end
         end
         mfac_pkg::ST_ADJ_OUT:
            if (rsp_ready) state_in = end_ff ? mfac_pkg::ST_DIV_START : mfac_pkg::ST_IDLE;
         mfac_pkg::ST_DIV_START:
            state_in = mfac_pkg::ST_DIV_WAIT;
         mfac_pkg::ST_DIV_WAIT:
            if (div_status.done) begin
               state_in = (axis_ff == mfac_pkg::AXIS_Z) ? mfac_pkg::ST_CEN_OUT
                                                        : mfac_pkg::ST_DIV_START;
            end
         mfac_pkg::ST_CEN_OUT:
            if (rsp_ready) state_in = mfac_pkg::ST_IDLE;
         default:
            state_in = mfac_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready          = (state_ff == mfac_pkg::ST_IDLE);
      req_accept         = req_valid && req_ready;
      rsp_valid          = (state_ff == mfac_pkg::ST_ADJ_OUT) ||
                           (state_ff == mfac_pkg::ST_CEN_OUT);
      rsp_result_kind    = (state_ff == mfac_pkg::ST_CEN_OUT) ? mfac_pkg::KIND_CENTROID
                                                              : mfac_pkg::KIND_ADJ;
      rsp_face_current   = face_ff;
      rsp_face_neighbour = '0;
      rsp_centroid_x     = '0;
      rsp_centroid_y     = '0;
      rsp_centroid_z     = '0;
      rsp_edges_dropped  = overflow_ff;
      rsp_run_last       = 1'b1;
      if (state_ff == mfac_pkg::ST_ADJ_OUT) begin
         rsp_face_neighbour = nb_ff;
         rsp_run_last       = !end_ff;
      end
      if (state_ff == mfac_pkg::ST_CEN_OUT) begin
         rsp_centroid_x = cen_x_ff;
         rsp_centroid_y = cen_y_ff;
         rsp_centroid_z = cen_z_ff;
      end

      tbl_cmd.start       = req_accept;
      tbl_cmd.key.v_start = va_ff;
      tbl_cmd.key.v_end   = vb_ff;
      tbl_cmd.key.face    = face_ff;

      unique case (axis_ff)
         mfac_pkg::AXIS_X: sel_sum = sum_x_ff;
         mfac_pkg::AXIS_Y: sel_sum = sum_y_ff;
         mfac_pkg::AXIS_Z: sel_sum = sum_z_ff;
         default:          sel_sum = sum_z_ff;
      endcase
      sel_mag          = sel_sum[SUM_W-1] ? (~sel_sum + SUM_W'(1)) : sel_sum;
      div_cmd.start    = (state_ff == mfac_pkg::ST_DIV_START);
      div_cmd.dividend = sel_mag;
      div_cmd.divisor  = (ccnt_ff == '0) ? CCNT_W'(1) : ccnt_ff;
   end

   // datapath next values
   always_comb begin
      face_in     = face_ff;
      va_in       = va_ff;
      vb_in       = vb_ff;
      end_in      = end_ff;
      sum_x_in    = sum_x_ff;
      sum_y_in    = sum_y_ff;
      sum_z_in    = sum_z_ff;
      ccnt_in     = ccnt_ff;
      overflow_in = overflow_ff;
      nb_in       = nb_ff;
      sign_in     = sign_ff;
      axis_in     = axis_ff;
      cen_x_in    = cen_x_ff;
      cen_y_in    = cen_y_ff;
      cen_z_in    = cen_z_ff;

      // mean magnitude never exceeds 2^31, so the low word carries it
      quo_lo   = div_status.quotient[POS_W-1:0];
      neg_val  = ~quo_lo + POS_W'(1);
      mean_val = sign_ff ? neg_val : quo_lo;

      if (req_accept) begin
         face_in = req_face_id;
         va_in   = req_corner_vertex;
         vb_in   = req_following_vertex;
         end_in  = req_face_end;
         axis_in = mfac_pkg::AXIS_X;
         if (ccnt_ff < mfac_pkg::MAX_CORNERS) begin
            sum_x_in = sum_x_ff + {{(SUM_W-POS_W){req_pos_x[POS_W-1]}}, req_pos_x};
            sum_y_in = sum_y_ff + {{(SUM_W-POS_W){req_pos_y[POS_W-1]}}, req_pos_y};
            sum_z_in = sum_z_ff + {{(SUM_W-POS_W){req_pos_z[POS_W-1]}}, req_pos_z};
            ccnt_in  = ccnt_ff + CCNT_W'(1);
         end
      end

      if ((state_ff == mfac_pkg::ST_SEARCH) && tbl_status.done) begin
         nb_in = tbl_status.neighbour;
         if (tbl_status.dropped) overflow_in = 1'b1;
      end

      if (state_ff == mfac_pkg::ST_DIV_START) sign_in = sel_sum[SUM_W-1];

      if ((state_ff == mfac_pkg::ST_DIV_WAIT) && div_status.done) begin
         unique case (axis_ff)
            mfac_pkg::AXIS_X: begin
               // x is negated; a mean of -2^31 saturates to the positive limit
               if (sign_ff) cen_x_in = quo_lo[POS_W-1] ? POS_MAX : quo_lo;
               else         cen_x_in = neg_val;
               axis_in = mfac_pkg::AXIS_Y;
            end
            mfac_pkg::AXIS_Y: begin
               cen_y_in = mean_val;
               axis_in  = mfac_pkg::AXIS_Z;
            end
            mfac_pkg::AXIS_Z: cen_z_in = mean_val;
            default:          cen_z_in = mean_val;
         endcase
      end

      if ((state_ff == mfac_pkg::ST_CEN_OUT) && rsp_ready) begin
         sum_x_in = '0;
         sum_y_in = '0;
         sum_z_in = '0;
         ccnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mfac_pkg::ST_IDLE;
         axis_ff     <= mfac_pkg::AXIS_X;
         sum_x_ff    <= '0;
         sum_y_ff    <= '0;
         sum_z_ff    <= '0;
         ccnt_ff     <= '0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         axis_ff     <= axis_in;
         sum_x_ff    <= sum_x_in;
         sum_y_ff    <= sum_y_in;
         sum_z_ff    <= sum_z_in;
         ccnt_ff     <= ccnt_in;
         overflow_ff <= overflow_in;
      end
      face_ff  <= face_in;
      va_ff    <= va_in;
      vb_ff    <= vb_in;
      end_ff   <= end_in;
      nb_ff    <= nb_in;
      sign_ff  <= sign_in;
      cen_x_ff <= cen_x_in;
      cen_y_ff <= cen_y_in;
      cen_z_ff <= cen_z_in;
   end

   `MFAC_ASSERT_IMPLIES(a_ready_excl, req_ready, !rsp_valid, "ready while a result is pending")
   `MFAC_ASSERT_IMPLIES(a_cen_last,
      rsp_valid && (rsp_result_kind == mfac_pkg::KIND_CENTROID), rsp_run_last,
      "centroid not last")
   `MFAC_ASSERT_NEXT(a_drop_sticky, rsp_edges_dropped, rsp_edges_dropped, "drop flag cleared")
   `MFAC_ASSERT_NEXT(a_adj_to_div,
      rsp_valid && rsp_ready && !rsp_run_last, state_ff == mfac_pkg::ST_DIV_START,
      "centroid not started after adjacency")

endmodule

// ===== hw/rtl/mfac_edge_table.sv =====
// Edge table: memory of undirected edges, in-order scan for a match, append on miss while there is room.
// Depends on mfac_pkg.
module mfac_edge_table #(
   parameter int EDGE_TABLE_DEPTH = mfac_pkg::EDGE_TABLE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mfac_pkg::tbl_cmd_type    cmd,
   output mfac_pkg::tbl_status_type status
);

   localparam int ADDR_W = $clog2(EDGE_TABLE_DEPTH);
   localparam int CNT_W  = $clog2(EDGE_TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(EDGE_TABLE_DEPTH);

   mfac_pkg::edge_entry_type mem [EDGE_TABLE_DEPTH];

   mfac_pkg::tbl_state_type  state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         addr_ff, addr_in;
   logic                     pend_ff, pend_in;
   mfac_pkg::edge_entry_type rd_data_ff;

   logic issue, hit, finish, room, do_write;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mfac_pkg::TBL_IDLE: if (cmd.start) state_in = mfac_pkg::TBL_SCAN;
         mfac_pkg::TBL_SCAN: if (finish) state_in = mfac_pkg::TBL_IDLE;
         default:            state_in = mfac_pkg::TBL_IDLE;
      endcase
   end

   // outputs and datapath next values
   always_comb begin
      issue    = 1'b0;
      hit      = 1'b0;
      finish   = 1'b0;
      room     = (count_ff < DEPTH_CNT);
      do_write = 1'b0;
      addr_in  = addr_ff;
      pend_in  = pend_ff;
      count_in = count_ff;
      unique case (state_ff)
         mfac_pkg::TBL_IDLE: begin
            if (cmd.start) begin
               addr_in = '0;
               pend_in = 1'b0;
            end
         end
         mfac_pkg::TBL_SCAN: begin
            issue = (addr_ff < count_ff);
            // direction ignored
            hit = pend_ff &&
                  (((rd_data_ff.v_start == cmd.key.v_start) &&
                    (rd_data_ff.v_end   == cmd.key.v_end)) ||
                   ((rd_data_ff.v_start == cmd.key.v_end) &&
                    (rd_data_ff.v_end   == cmd.key.v_start)));
            finish   = hit || (!issue && !pend_ff);
            do_write = finish && !hit && room;
            pend_in  = issue && !finish;
            if (issue) addr_in = addr_ff + CNT_W'(1);
            if (do_write) count_in = count_ff + CNT_W'(1);
         end
         default: ;
      endcase
      status.done      = finish;
      status.found     = hit;
      status.dropped   = finish && !hit && !room;
      status.neighbour = rd_data_ff.face;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfac_pkg::TBL_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      addr_ff <= addr_in;
   end

   always_ff @(posedge clock) begin
      if (issue) rd_data_ff <= mem[addr_ff[ADDR_W-1:0]];
      if (do_write) mem[count_ff[ADDR_W-1:0]] <= cmd.key;
   end

endmodule

// ===== hw/rtl/mfac_divider.sv =====
// Shared restoring divider, one quotient bit per cycle, unsigned 40 by 8 bits.
// Depends on mfac_pkg.
module mfac_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  mfac_pkg::div_cmd_type    cmd,
   output mfac_pkg::div_status_type status
);

   localparam int SUM_W  = mfac_pkg::SUM_W;
   localparam int CCNT_W = mfac_pkg::CCNT_W;
   localparam int STEP_W = $clog2(SUM_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CCNT_W-1:0] rem_ff, rem_in;
   logic [CCNT_W-1:0] div_ff, div_in;

   logic [CCNT_W:0] trial, diff;
   logic            ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      diff    = trial - {1'b0, div_ff};
      ge      = (trial >= {1'b0, div_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = cmd.dividend;
         rem_in  = '0;
         div_in  = cmd.divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits the narrow register
         rem_in  = ge ? diff[CCNT_W-1:0] : trial[CCNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], ge};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      status.done     = done_ff;
      status.quotient = quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

endmodule

// ===== tb/sv/tb_mesh_face_adjacency_and_centroid.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for mesh_face_adjacency_and_centroid.
// Depends on mfac_pkg and the block's RTL. A built-in predictor tracks the shared-edge
// table and the face sums, and every result is compared with the predicted one.

module tb_mesh_face_adjacency_and_centroid;

   localparam int TABLE_DEPTH    = mfac_pkg::EDGE_TABLE_DEPTH_DEF;
   localparam int CYCLE_LIMIT    = 10_000_000;
   localparam int POOL_SIZE      = 16;
   localparam int RANDOM_UNTIL   = 750;
   localparam int QUIET_ITEMS    = 150;
   localparam int REPORT_LIMIT   = 10;
   localparam int TAIL_CYCLES    = 1500;

   typedef struct packed {
      logic [15:0]        face;
      logic [15:0]        va;
      logic [15:0]        vb;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               last;
   } corner_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] face_cur;
      logic [15:0] face_nb;
      logic [31:0] cx;
      logic [31:0] cy;
      logic [31:0] cz;
      logic        dropped;
      logic        last;
   } face_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_face_id = '0;
   logic [15:0] req_corner_vertex = '0;
   logic [15:0] req_following_vertex = '0;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [31:0] req_pos_z = '0;
   logic        req_face_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_result_kind;
   logic [15:0] rsp_face_current;
   logic [15:0] rsp_face_neighbour;
   logic signed [31:0] rsp_centroid_x;
   logic signed [31:0] rsp_centroid_y;
   logic signed [31:0] rsp_centroid_z;
   logic        rsp_edges_dropped;
   logic        rsp_run_last;

   // predictor state
   logic [15:0]     tbl_va   [TABLE_DEPTH];
   logic [15:0]     tbl_vb   [TABLE_DEPTH];
   logic [15:0]     tbl_face [TABLE_DEPTH];
   int              edges_stored = 0;
   longint          acc_x = 0;
   longint          acc_y = 0;
   longint          acc_z = 0;
   int              corners_summed = 0;
   logic            drop_seen = 1'b0;
   face_result_type pending_results[$];

   logic [15:0]  vertex_pool [POOL_SIZE];
   bit           stall_enable = 1'b1;
   int           items_sent = 0;
   int           mismatches = 0;
   int           cycle_count = 0;

   mesh_face_adjacency_and_centroid #(
      .EDGE_TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_face_id         (req_face_id),
      .req_corner_vertex   (req_corner_vertex),
      .req_following_vertex(req_following_vertex),
      .req_pos_x           (req_pos_x),
      .req_pos_y           (req_pos_y),
      .req_pos_z           (req_pos_z),
      .req_face_end        (req_face_end),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_face_current    (rsp_face_current),
      .rsp_face_neighbour  (rsp_face_neighbour),
      .rsp_centroid_x      (rsp_centroid_x),
      .rsp_centroid_y      (rsp_centroid_y),
      .rsp_centroid_z      (rsp_centroid_z),
      .rsp_edges_dropped   (rsp_edges_dropped),
      .rsp_run_last        (rsp_run_last)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_mesh_face_adjacency_and_centroid NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !(stall_enable && $urandom_range(99) < 25);
   end

   // undirected search, first entry in table order wins
   function automatic bit lookup_shared_edge(input logic [15:0] va, input logic [15:0] vb,
                                             output logic [15:0] owner);
      owner = '0;
      for (int i = 0; i < edges_stored; i++) begin
         if ((tbl_va[i] == va && tbl_vb[i] == vb) || (tbl_va[i] == vb && tbl_vb[i] == va)) begin
            owner = tbl_face[i];
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void compute_adjacency_and_centroid(input corner_type c);
      logic [15:0]     owner;
      bit              hit;
      longint          cnt;
      longint          neg_x;
      face_result_type r;
      if (corners_summed < int'(mfac_pkg::MAX_CORNERS)) begin
         acc_x += longint'(c.x);
         acc_y += longint'(c.y);
         acc_z += longint'(c.z);
         corners_summed++;
      end
      hit = lookup_shared_edge(c.va, c.vb, owner);
      if (!hit) begin
         if (edges_stored < TABLE_DEPTH) begin
            tbl_va[edges_stored]   = c.va;
            tbl_vb[edges_stored]   = c.vb;
            tbl_face[edges_stored] = c.face;
            edges_stored++;
         end else begin
            drop_seen = 1'b1;
         end
      end
      if (hit) begin
         r = '0;
         r.kind     = mfac_pkg::KIND_ADJ;
         r.face_cur = c.face;
         r.face_nb  = owner;
         r.dropped  = drop_seen;
         r.last     = !c.last;
         pending_results.insert(pending_results.size(), r);
      end
      if (c.last) begin
         cnt = (corners_summed != 0) ? longint'(corners_summed) : 64'sd1;
         // longint division truncates toward zero
         neg_x = -(acc_x / cnt);
         if (neg_x > 64'sd2147483647)
            neg_x = 64'sd2147483647;
         r = '0;
         r.kind     = mfac_pkg::KIND_CENTROID;
         r.face_cur = c.face;
         r.cx       = neg_x[31:0];
         r.cy       = 32'(acc_y / cnt);
         r.cz       = 32'(acc_z / cnt);
         r.dropped  = drop_seen;
         r.last     = 1'b1;
         pending_results.insert(pending_results.size(), r);
         acc_x = 0;
         acc_y = 0;
         acc_z = 0;
         corners_summed = 0;
      end
   endfunction

   function automatic string result_text(input face_result_type r);
      return $sformatf("kind=%0d cur=%h nb=%h x=%h y=%h z=%h drop=%0d last=%0d",
                       r.kind, r.face_cur, r.face_nb, r.cx, r.cy, r.cz, r.dropped, r.last);
   endfunction

   always @(posedge clock) begin
      face_result_type got;
      face_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.kind     = rsp_result_kind;
         got.face_cur = rsp_face_current;
         got.face_nb  = rsp_face_neighbour;
         got.cx       = rsp_centroid_x;
         got.cy       = rsp_centroid_y;
         got.cz       = rsp_centroid_z;
         got.dropped  = rsp_edges_dropped;
         got.last     = rsp_run_last;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result: %s", result_text(got));
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("mismatch: expected %s", result_text(want));
                  $display("          actual   %s", result_text(got));
               end
            end
         end
      end
   end

   function automatic corner_type mk_corner(input logic [15:0] face, input logic [15:0] va,
                                            input logic [15:0] vb, input logic [31:0] x,
                                            input logic [31:0] y, input logic [31:0] z,
                                            input logic last);
      corner_type c;
      c.face = face;
      c.va   = va;
      c.vb   = vb;
      c.x    = x;
      c.y    = y;
      c.z    = z;
      c.last = last;
      return c;
   endfunction

   function automatic logic signed [31:0] rand_coord();
      int unsigned pick;
      pick = $urandom_range(3);
      if (pick == 3) begin
         case ($urandom_range(3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            default: return '1;
         endcase
      end
      if (pick == 2)
         return $signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000;
      return $urandom;
   endfunction

   task automatic send_corner(input corner_type c);
      while (stall_enable && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      compute_adjacency_and_centroid(c);
      req_valid            <= 1'b1;
      req_face_id          <= c.face;
      req_corner_vertex    <= c.va;
      req_following_vertex <= c.vb;
      req_pos_x            <= c.x;
      req_pos_y            <= c.y;
      req_pos_z            <= c.z;
      req_face_end         <= c.last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_pool_face();
      logic [15:0] verts [10];
      logic [15:0] fid;
      int          n;
      n   = ($urandom_range(9) == 0) ? $urandom_range(1, 10) : $urandom_range(3, 6);
      fid = 16'($urandom);
      for (int k = 0; k < n; k++)
         verts[k] = vertex_pool[$urandom_range(POOL_SIZE - 1)];
      for (int k = 0; k < n; k++)
         send_corner(mk_corner(fid, verts[k], verts[(k + 1) % n], rand_coord(), rand_coord(),
                               rand_coord(), k == n - 1));
   endtask

   task automatic send_noise_corner();
      logic [15:0] va;
      logic [15:0] vb;
      va = ($urandom_range(4) == 0) ? 16'($urandom) : vertex_pool[$urandom_range(POOL_SIZE - 1)];
      vb = ($urandom_range(4) == 0) ? 16'($urandom) : vertex_pool[$urandom_range(POOL_SIZE - 1)];
      send_corner(mk_corner(16'($urandom), va, vb, rand_coord(), rand_coord(), rand_coord(),
                            1'($urandom_range(1))));
   endtask

   // corner whose edge is not in the table yet
   function automatic corner_type fresh_corner(input logic [15:0] face, input logic last);
      logic [15:0] va;
      logic [15:0] vb;
      logic [15:0] owner;
      do begin
         va = 16'($urandom);
         vb = 16'($urandom);
      end while (lookup_shared_edge(va, vb, owner));
      return mk_corner(face, va, vb, rand_coord(), rand_coord(), rand_coord(), last);
   endfunction

   task automatic test_directed_faces();
      // extreme ids and positions, matches in reverse direction
      send_corner(mk_corner(16'h0000, 16'h0000, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 1'b0));
      send_corner(mk_corner(16'h0000, 16'hFFFF, 16'h0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 1'b0));
      send_corner(mk_corner(16'h0000, 16'h0001, 16'h0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 1'b1));
      send_corner(mk_corner(16'hFFFF, 16'hFFFF, 16'h0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 1'b0));
      send_corner(mk_corner(16'hFFFF, 16'h0000, 16'h0001, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 1'b0));
      // match plus face end: two results, negated x saturates
      send_corner(mk_corner(16'hFFFF, 16'h0001, 16'hFFFF, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 1'b1));
      // self loop, matched by its own face
      send_corner(mk_corner(16'd7, 16'd5, 16'd5, -32'sd1, -32'sd2, 32'sd5, 1'b0));
      send_corner(mk_corner(16'd7, 16'd5, 16'd5, 32'sd0, 32'sd0, 32'sd0, 1'b0));
      // face number changes without face end, sums carry; rounding toward zero
      send_corner(mk_corner(16'd8, 16'd5, 16'd6, 32'sd0, 32'sd0, 32'sd0, 1'b1));
      // single corner face
      send_corner(mk_corner(16'd9, 16'd6, 16'd5, -32'sd5, 32'sd5, -32'sd7, 1'b1));
      send_corner(mk_corner(16'd10, 16'd100, 16'd101, 32'sd5, -32'sd5, 32'sd7, 1'b0));
      send_corner(mk_corner(16'd10, 16'd101, 16'd100, 32'sd0, 32'sd0, 32'sd0, 1'b1));
      // alternating bit patterns
      send_corner(mk_corner(16'hAAAA, 16'hAAAA, 16'h5555, 32'h5555_5555, 32'hAAAA_AAAA,
                            32'h1234_5678, 1'b1));
      send_corner(mk_corner(16'h5555, 16'h5555, 16'hAAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                            32'hEDCB_A988, 1'b1));
      send_corner(mk_corner(16'h5555, 16'hAAAA, 16'hAAAA, 32'h0000_0001, 32'hFFFF_FFFF,
                            32'h0001_0000, 1'b0));
      send_corner(mk_corner(16'h5556, 16'hAAAA, 16'hAAAA, 32'h0000_0002, 32'hFFFF_FFFE,
                            32'hFFFF_0000, 1'b1));
      wait_all_results();
   endtask

   // corners beyond the 255th are matched but left out of the sums
   task automatic test_corner_limit();
      logic [31:0] x;
      logic [31:0] y;
      for (int k = 0; k < 260; k++) begin
         x = (k < 255) ? 32'h7FFF_FFFF : 32'h8000_0000;
         y = (k < 255) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         send_corner(mk_corner(16'h1234, 16'(200 + k % 4), 16'(200 + (k + 1) % 4), x, y,
                               32'(k * 3), k == 259));
      end
      wait_all_results();
   endtask

   task automatic test_random_mesh();
      int quiet_from;
      for (int k = 0; k < POOL_SIZE; k++)
         vertex_pool[k] = 16'($urandom);
      quiet_from = items_sent + 200;
      while (items_sent < RANDOM_UNTIL) begin
         stall_enable = !(items_sent >= quiet_from && items_sent < quiet_from + QUIET_ITEMS);
         if ($urandom_range(9) == 0)
            send_noise_corner();
         else
            send_pool_face();
         if ($urandom_range(49) == 0)
            wait_all_results();
      end
      stall_enable = 1'b1;
   endtask

   task automatic test_table_overflow();
      logic [15:0] fid;
      int          k;
      int          idx;
      k   = 0;
      fid = 16'($urandom);
      while (edges_stored < TABLE_DEPTH) begin
         if (k % 4 == 0)
            fid = 16'($urandom);
         send_corner(fresh_corner(fid, k % 4 == 3));
         k++;
      end
      // table full: unmatched edges are dropped, the flag sticks
      send_corner(fresh_corner(16'hBEEF, 1'b0));
      send_corner(fresh_corner(16'hBEEF, 1'b1));
      send_corner(mk_corner(16'hC0DE, tbl_vb[TABLE_DEPTH - 1], tbl_va[TABLE_DEPTH - 1],
                            rand_coord(), rand_coord(), rand_coord(), 1'b1));
      send_corner(mk_corner(16'hC0DF, tbl_va[0], tbl_vb[0], rand_coord(), rand_coord(),
                            rand_coord(), 1'b0));
      wait_all_results();
      for (int n = 0; n < 8; n++) begin
         idx = $urandom_range(TABLE_DEPTH - 1);
         send_corner(mk_corner(16'($urandom), tbl_va[idx], tbl_vb[idx], rand_coord(),
                               rand_coord(), rand_coord(), 1'($urandom_range(1))));
      end
      for (int n = 0; n < 6; n++)
         send_pool_face();
      send_corner(fresh_corner(16'hFACE, 1'b1));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_faces();
      test_corner_limit();
      test_random_mesh();
      test_table_overflow();
      wait_all_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb_mesh_face_adjacency_and_centroid OK");
      else
         $display("tb_mesh_face_adjacency_and_centroid NOT OK");
      $finish;
   end

endmodule
